// File: hdl/sal_pkg.sv
// shared types, codes and constants for the session admission ledger
`default_nettype none
package sal_pkg;

    localparam int DEF_TABLE_SLOTS = 16;
    localparam int ID_W            = 16;
    localparam int CNT_W           = 5;
    localparam int REFUSE_W        = 16;
    localparam int APB_ADDR_W      = 4;
    localparam int APB_DATA_W      = 32;

    localparam logic [CNT_W-1:0]    CNT_MAX    = '1;
    localparam logic [REFUSE_W-1:0] REFUSE_MAX = '1;

    // operation codes
    localparam logic [1:0] OP_REQUEST  = 2'd0;
    localparam logic [1:0] OP_TRANSFER = 2'd1;
    localparam logic [1:0] OP_RELEASE  = 2'd2;

    // register indexes (word address)
    localparam logic [1:0] REG_HEAVY_CAP     = 2'd0;
    localparam logic [1:0] REG_GUARD_ARMED   = 2'd1;
    localparam logic [1:0] REG_LIGHT_CEILING = 2'd2;

    localparam logic [3:0] HEAVY_CAP_RST     = 4'd0;
    localparam logic       GUARD_ARMED_RST   = 1'b0;
    localparam logic [4:0] LIGHT_CEILING_RST = 5'd4;

    typedef enum logic [2:0] {
        ST_NEW     = 3'd0,
        ST_HELD    = 3'd1,
        ST_CAP     = 3'd2,
        ST_FULL    = 3'd3,
        ST_MOVED   = 3'd4,
        ST_NOSRC   = 3'd5,
        ST_FREED   = 3'd6,
        ST_NOTHELD = 3'd7
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]      operation;
        logic [ID_W-1:0] session_id;
        logic [ID_W-1:0] target_id;
        logic            heavy_class;
    } t_req;

    typedef struct packed {
        logic [2:0]          status;
        logic                admitted;
        logic [CNT_W-1:0]    active_heavy;
        logic [CNT_W-1:0]    active_light;
        logic [REFUSE_W-1:0] refusal_total;
        logic                light_over_ceiling;
        logic                over_cap_unguarded;
    } t_rsp;

    typedef struct packed {
        logic [3:0] heavy_cap;
        logic       guard_armed;
        logic [4:0] light_ceiling;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage
`default_nettype wire

// File: hdl/sal_regs.sv
// configuration registers behind the apb port
`default_nettype none
module sal_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sal_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sal_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sal_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output sal_pkg::t_cfg                       o_cfg
);
    import sal_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heavy_cap     <= HEAVY_CAP_RST;
            r_cfg.guard_armed   <= GUARD_ARMED_RST;
            r_cfg.light_ceiling <= LIGHT_CEILING_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_HEAVY_CAP:     r_cfg.heavy_cap     <= pwdata[3:0];
                REG_GUARD_ARMED:   r_cfg.guard_armed   <= pwdata[0];
                REG_LIGHT_CEILING: r_cfg.light_ceiling <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HEAVY_CAP:     prdata = APB_DATA_W'(r_cfg.heavy_cap);
            REG_GUARD_ARMED:   prdata = APB_DATA_W'(r_cfg.guard_armed);
            REG_LIGHT_CEILING: prdata = APB_DATA_W'(r_cfg.light_ceiling);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: hdl/sal_ctrl.sv
// controller state machine: capture then execute one transaction
`default_nettype none
module sal_ctrl (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    output logic         o_busy,
    output sal_pkg::t_cmd o_cmd
);
    import sal_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = i_start ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_busy        = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_start;
            end
            S_EXEC: begin
                o_busy        = 1'b1;
                o_cmd.execute = 1'b1;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/sal_dp.sv
// datapath: session table with parallel id match, counters and result register
`default_nettype none
module sal_dp #(
    parameter int TABLE_SLOTS = sal_pkg::DEF_TABLE_SLOTS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sal_pkg::t_cmd i_cmd,
    input  wire sal_pkg::t_req i_req,
    input  wire sal_pkg::t_cfg i_cfg,
    output logic               o_done,
    output sal_pkg::t_rsp      o_rsp
);
    import sal_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    logic [TABLE_SLOTS-1:0] r_valid;
    logic [ID_W-1:0]        r_id    [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_heavy;
    logic [CNT_W-1:0]       r_heavy_cnt, n_heavy_cnt;
    logic [CNT_W-1:0]       r_light_cnt, n_light_cnt;
    logic [REFUSE_W-1:0]    r_refusals,  n_refusals;
    t_req                   r_req;
    logic [TABLE_SLOTS-1:0] r_src_hit;
    logic [TABLE_SLOTS-1:0] r_tgt_hit;
    t_rsp                   r_rsp, n_rsp;
    logic                   r_done;

    logic             src_found, tgt_found, free_found;
    logic [IDX_W-1:0] src_idx, tgt_idx, free_idx;
    logic             src_heavy, refusing;
    logic             wr_new, mv_class, mv_id, free_src;
    logic [CNT_W-1:0] heavy_inc, light_inc, heavy_dec, light_dec;

    // first matching slot for source and target, first free slot
    always_comb begin
        src_idx  = '0;
        tgt_idx  = '0;
        free_idx = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (r_src_hit[i]) src_idx = IDX_W'(i);
            if (r_tgt_hit[i]) tgt_idx = IDX_W'(i);
            if (!r_valid[i])  free_idx = IDX_W'(i);
        end
    end

    assign src_found  = |r_src_hit;
    assign tgt_found  = |r_tgt_hit;
    assign free_found = ~&r_valid;
    assign src_heavy  = r_heavy[src_idx];
    assign refusing   = i_cfg.guard_armed && (i_cfg.heavy_cap != '0);

    assign heavy_inc = (r_heavy_cnt == CNT_MAX) ? CNT_MAX : r_heavy_cnt + 1'b1;
    assign light_inc = (r_light_cnt == CNT_MAX) ? CNT_MAX : r_light_cnt + 1'b1;
    assign heavy_dec = (r_heavy_cnt == '0) ? '0 : r_heavy_cnt - 1'b1;
    assign light_dec = (r_light_cnt == '0) ? '0 : r_light_cnt - 1'b1;

    always_comb begin
        n_heavy_cnt = r_heavy_cnt;
        n_light_cnt = r_light_cnt;
        n_refusals  = r_refusals;
        wr_new      = 1'b0;
        mv_class    = 1'b0;
        mv_id       = 1'b0;
        free_src    = 1'b0;
        n_rsp.status             = ST_NOTHELD;
        n_rsp.admitted           = 1'b1;
        n_rsp.light_over_ceiling = 1'b0;
        n_rsp.over_cap_unguarded = 1'b0;
        unique case (r_req.operation)
            OP_REQUEST: begin
                priority if (src_found) begin
                    n_rsp.status = ST_HELD;
                end else if (r_req.heavy_class && refusing
                             && (r_heavy_cnt >= CNT_W'(i_cfg.heavy_cap))) begin
                    n_rsp.status   = ST_CAP;
                    n_rsp.admitted = 1'b0;
                    if (r_refusals != REFUSE_MAX) n_refusals = r_refusals + 1'b1;
                end else if (!free_found) begin
                    n_rsp.status   = ST_FULL;
                    n_rsp.admitted = 1'b0;
                end else begin
                    n_rsp.status = ST_NEW;
                    wr_new       = 1'b1;
                    if (r_req.heavy_class) begin
                        n_heavy_cnt = heavy_inc;
                        n_rsp.over_cap_unguarded = !refusing
                            && (i_cfg.heavy_cap != '0)
                            && (heavy_inc > CNT_W'(i_cfg.heavy_cap));
                    end else begin
                        n_light_cnt = light_inc;
                        n_rsp.light_over_ceiling = light_inc > i_cfg.light_ceiling;
                    end
                end
            end
            OP_TRANSFER: begin
                if (!src_found) begin
                    n_rsp.status = ST_NOSRC;
                end else begin
                    n_rsp.status = ST_MOVED;
                    // target held by another entry: it takes the class, source goes
                    if (tgt_found && (tgt_idx != src_idx)) begin
                        mv_class = 1'b1;
                    end else begin
                        mv_id = 1'b1;
                    end
                end
            end
            OP_RELEASE: begin
                if (src_found) begin
                    n_rsp.status = ST_FREED;
                    free_src     = 1'b1;
                    if (src_heavy) n_heavy_cnt = heavy_dec;
                    else           n_light_cnt = light_dec;
                end
            end
            default: ;
        endcase
        n_rsp.active_heavy  = n_heavy_cnt;
        n_rsp.active_light  = n_light_cnt;
        n_rsp.refusal_total = n_refusals;
    end

    // control state of the table and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_heavy_cnt <= '0;
            r_light_cnt <= '0;
            r_refusals  <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_cmd.execute;
            if (i_cmd.execute) begin
                r_heavy_cnt <= n_heavy_cnt;
                r_light_cnt <= n_light_cnt;
                r_refusals  <= n_refusals;
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (wr_new && (free_idx == IDX_W'(i))) r_valid[i] <= 1'b1;
                    if ((mv_class || free_src) && (src_idx == IDX_W'(i)))
                        r_valid[i] <= 1'b0;
                end
            end
        end
    end

    // table payload and transaction capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_src_hit[i] <= r_valid[i] && (r_id[i] == i_req.session_id);
                r_tgt_hit[i] <= r_valid[i] && (r_id[i] == i_req.target_id);
            end
        end
        if (i_cmd.execute) begin
            r_rsp <= n_rsp;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (wr_new && (free_idx == IDX_W'(i))) begin
                    r_id[i]    <= r_req.session_id;
                    r_heavy[i] <= r_req.heavy_class;
                end
                if (mv_id && (src_idx == IDX_W'(i)))    r_id[i]    <= r_req.target_id;
                if (mv_class && (tgt_idx == IDX_W'(i))) r_heavy[i] <= src_heavy;
            end
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
`default_nettype wire

// File: hdl/session_admission_ledger_top.sv
// a transaction is accepted by start while idle; an id match stage registers the table hits,
// then a table update stage writes the table and the result register and raises o_done
// a new transaction is not taken while the ledger is busy with the update of the last one
// busy is high for the single cycle of the update; the receiver cannot stall results
// reset (synchronous, active low) clears all entry valid bits, the counters and the
// registers to their defaults; there is no clearing pass
`default_nettype none
module session_admission_ledger_top #(
    parameter int TABLE_SLOTS = sal_pkg::DEF_TABLE_SLOTS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire sal_pkg::t_req                  i_req,
    output logic                                o_done,
    output sal_pkg::t_rsp                       o_rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sal_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sal_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sal_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import sal_pkg::*;

    t_cfg cfg;
    t_cmd cmd;

    sal_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    sal_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .i_cfg   (cfg),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // every accepted transaction raises busy and then gets its result strobe
    a_done_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 o_done)
        else $error("result strobe missing after accepted transaction");

    // no result without a preceding update cycle
    a_done_follows_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without update cycle");

    // refusal only with a refusing status
    a_refusal_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.admitted) |->
            (o_rsp.status == ST_CAP || o_rsp.status == ST_FULL))
        else $error("refused transaction with wrong status");

endmodule
`default_nettype wire
